// ===== hdl/dstp_pkg.sv =====
`default_nettype none

package dstp_pkg;

    // Field widths of the number item and the result item
    localparam int CHAR_W = 8;
    localparam int ACC_W  = 60;
    localparam int SIG_W  = 61;
    localparam int POW_W  = 12;
    localparam int FRAC_W = 8;
    localparam int EXP_W  = 10;
    localparam int DIG_W  = 4;

    localparam int MAX_SIG_DIGITS_DEF = 18;

    localparam logic [FRAC_W-1:0] FRAC_LIMIT = 8'd255;
    localparam logic [EXP_W-1:0]  EXP_LIMIT  = 10'd999;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_E_UP  = 8'h45;
    localparam logic [CHAR_W-1:0] CH_E_LO  = 8'h65;

    // Parse phases
    typedef logic [2:0] t_phase;
    localparam t_phase PH_SPACE     = 3'd0;
    localparam t_phase PH_INT       = 3'd1;
    localparam t_phase PH_FRAC      = 3'd2;
    localparam t_phase PH_EXP_SIGN  = 3'd3;
    localparam t_phase PH_EXP_DIGIT = 3'd4;
    localparam t_phase PH_DONE      = 3'd5;

    typedef struct packed {
        t_phase            phase;
        logic              val_neg;
        logic [ACC_W-1:0]  acc;
        logic [FRAC_W-1:0] frac;
        logic              exp_neg;
        logic [EXP_W-1:0]  exp;
        logic              ovf;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:   PH_SPACE,
        val_neg: 1'b0,
        acc:     '0,
        frac:    '0,
        exp_neg: 1'b0,
        exp:     '0,
        ovf:     1'b0
    };

    // Smallest accumulator value that already holds the full digit count
    function automatic logic [ACC_W-1:0] sig_threshold(input int digits);
        logic [ACC_W-1:0] t;
        t = ACC_W'(1);
        for (int k = 1; k < 18; k++) begin
            if (k < digits) begin
                t = ACC_W'(t * ACC_W'(10));
            end
        end
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/dstp_step.sv =====
`default_nettype none

module dstp_step
    import dstp_pkg::*;
#(
    parameter int MAX_SIG_DIGITS = MAX_SIG_DIGITS_DEF
) (
    input  wire t_state            i_state,
    input  wire logic [CHAR_W-1:0] i_char,
    output t_state                 o_state
);

    localparam logic [ACC_W-1:0] THRESH = sig_threshold(MAX_SIG_DIGITS);

    logic              is_digit;
    logic              is_space;
    logic              is_sign;
    logic              is_exp;
    logic [DIG_W-1:0]  digit;
    logic              full;
    logic [ACC_W-1:0]  acc_x10;
    logic [13:0]       exp_x10;
    logic              do_number;
    t_phase            work_phase;

    always_comb begin
        is_digit = i_char inside {[CH_ZERO:CH_NINE]};
        is_space = (i_char == CH_SPACE) || (i_char inside {[CH_TAB:CH_CR]});
        is_sign  = (i_char == CH_PLUS) || (i_char == CH_MINUS);
        is_exp   = (i_char == CH_E_LO) || (i_char == CH_E_UP);
        digit    = DIG_W'(i_char - CH_ZERO);
        full     = i_state.acc >= THRESH;
        acc_x10  = (i_state.acc << 3) + (i_state.acc << 1) + ACC_W'(digit);
        exp_x10  = (14'(i_state.exp) << 3) + (14'(i_state.exp) << 1) + 14'(digit);
    end

    always_comb begin
        o_state    = i_state;
        do_number  = 1'b0;
        work_phase = i_state.phase;

        // Leading white space and sign; anything else falls into the integer part
        if (i_state.phase == PH_SPACE) begin
            if (is_sign) begin
                o_state.val_neg = (i_char == CH_MINUS);
                o_state.phase   = PH_INT;
            end else if (!is_space) begin
                do_number  = 1'b1;
                work_phase = PH_INT;
            end
        end else if (i_state.phase != PH_DONE) begin
            do_number = 1'b1;
        end

        if (do_number) begin
            case (work_phase)
                PH_INT: begin
                    if (is_digit) begin
                        if (full) begin
                            o_state.ovf = 1'b1;
                        end else begin
                            o_state.acc = acc_x10;
                        end
                        o_state.phase = PH_INT;
                    end else if (i_char == CH_POINT) begin
                        o_state.phase = PH_FRAC;
                    end else if (is_exp) begin
                        o_state.phase = PH_EXP_SIGN;
                    end else begin
                        o_state.phase = PH_DONE;
                    end
                end
                PH_FRAC: begin
                    if (is_digit) begin
                        if (full) begin
                            o_state.ovf = 1'b1;
                        end else begin
                            o_state.acc = acc_x10;
                            if (i_state.frac < FRAC_LIMIT) begin
                                o_state.frac = i_state.frac + FRAC_W'(1);
                            end
                        end
                    end else if (is_exp) begin
                        o_state.phase = PH_EXP_SIGN;
                    end else begin
                        o_state.phase = PH_DONE;
                    end
                end
                PH_EXP_SIGN, PH_EXP_DIGIT: begin
                    if (is_digit) begin
                        o_state.exp   = (exp_x10 > 14'(EXP_LIMIT)) ? EXP_LIMIT
                                                                  : EXP_W'(exp_x10);
                        o_state.phase = PH_EXP_DIGIT;
                    end else if (work_phase == PH_EXP_SIGN && is_sign) begin
                        o_state.exp_neg = (i_char == CH_MINUS);
                        o_state.phase   = PH_EXP_DIGIT;
                    end else begin
                        o_state.phase = PH_DONE;
                    end
                end
                default: begin
                    o_state.phase = PH_DONE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/decimal_scientific_text_parser.sv =====
`default_nettype none

// Decimal number text parser. Feed one ASCII character per item on
// i_char_code, with i_last_char set on the final one; after leading white
// space it reads sign, integer digits, point, fraction digits and an e/E
// exponent, stops at the first character that does not fit, and on the last
// character returns one result item: o_significand (signed digits kept),
// o_power_of_ten (exponent minus kept fraction digits, exponent saturating
// at 999) and o_digits_dropped (digits beyond MAX_SIG_DIGITS ignored).
// Strings without the end mark produce nothing. The block takes one
// character every cycle unless a last character must wait for room for its
// result. A result passes through three register stages: the input
// register, the character step (a 60-bit multiply-by-ten add and a digit
// limit compare) writing the parse state and result capture, and the output
// stage that applies the sign to the significand and forms the power of ten.

module decimal_scientific_text_parser
    import dstp_pkg::*;
#(
    parameter int MAX_SIG_DIGITS = MAX_SIG_DIGITS_DEF
) (
    input  wire  logic                    i_clk,
    input  wire  logic                    i_rst_n,
    // Character input channel
    input  wire  logic                    i_valid,
    output logic                          o_ready,
    input  wire  logic [CHAR_W-1:0]       i_char_code,
    input  wire  logic                    i_last_char,
    // Result output channel
    output logic                          o_valid,
    input  wire  logic                    i_ready,
    output logic signed [SIG_W-1:0]       o_significand,
    output logic signed [POW_W-1:0]       o_power_of_ten,
    output logic                          o_digits_dropped
);

    // Input register
    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_last;

    // Parse state
    t_state            r_state;
    t_state            n_state;
    t_state            step_state;

    // Captured result, before sign and power are applied
    logic              r_res_valid;
    logic [ACC_W-1:0]  r_res_mag;
    logic              r_res_neg;
    logic [EXP_W-1:0]  r_res_exp;
    logic              r_res_eneg;
    logic [FRAC_W-1:0] r_res_frac;
    logic              r_res_ovf;

    // Output register
    logic              r_out_valid;
    logic [SIG_W-1:0]  r_out_sig;
    logic [POW_W-1:0]  r_out_pow;
    logic              r_out_drop;
    logic [SIG_W-1:0]  n_out_sig;
    logic [POW_W-1:0]  n_out_pow;

    // Stage enables, from the output side back to the input
    logic              out_load;
    logic              res_load_ok;
    logic              in_advance;
    logic              res_capture;

    dstp_step #(
        .MAX_SIG_DIGITS (MAX_SIG_DIGITS)
    ) u_step (
        .i_state (r_state),
        .i_char  (r_in_char),
        .o_state (step_state)
    );

    always_comb begin
        out_load    = !r_out_valid || i_ready;
        res_load_ok = !r_res_valid || out_load;
        // A plain character always moves on; a last character needs room for its result
        in_advance  = r_in_valid && (!r_in_last || res_load_ok);
        res_capture = in_advance && r_in_last;
        o_ready     = !r_in_valid || in_advance;
    end

    // Advance the parse state; return to reset after the last character
    always_comb begin
        n_state = r_state;
        if (in_advance) begin
            n_state = r_in_last ? STATE_RESET : step_state;
        end
    end

    // Apply sign and net power of ten
    always_comb begin
        logic [SIG_W-1:0] mag;
        logic [POW_W-1:0] e_abs;
        logic [POW_W-1:0] e_sgn;
        mag       = {1'b0, r_res_mag};
        e_abs     = POW_W'(r_res_exp);
        e_sgn     = r_res_eneg ? -e_abs : e_abs;
        n_out_sig = r_res_neg ? -mag : mag;
        n_out_pow = e_sgn - POW_W'(r_res_frac);
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_res_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            r_state <= n_state;
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (res_capture) begin
                r_res_valid <= 1'b1;
            end else if (out_load) begin
                r_res_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= r_res_valid;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_in_char <= i_char_code;
            r_in_last <= i_last_char;
        end
        if (res_capture) begin
            r_res_mag  <= step_state.acc;
            r_res_neg  <= step_state.val_neg;
            r_res_exp  <= step_state.exp;
            r_res_eneg <= step_state.exp_neg;
            r_res_frac <= step_state.frac;
            r_res_ovf  <= step_state.ovf;
        end
        if (out_load && r_res_valid) begin
            r_out_sig  <= n_out_sig;
            r_out_pow  <= n_out_pow;
            r_out_drop <= r_res_ovf;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_significand    = $signed(r_out_sig);
    assign o_power_of_ten   = $signed(r_out_pow);
    assign o_digits_dropped = r_out_drop;

endmodule

`default_nettype wire

// ===== hdl/dstp_checker.sv =====
`default_nettype none

module dstp_checker
    import dstp_pkg::*;
(
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_valid,
    input wire logic                    o_ready,
    input wire logic                    i_last_char,
    input wire logic                    o_valid,
    input wire logic                    i_ready,
    input wire logic signed [SIG_W-1:0] o_significand,
    input wire logic signed [POW_W-1:0] o_power_of_ten,
    input wire logic                    o_digits_dropped
);

    localparam logic signed [SIG_W-1:0] SIG_MAX = SIG_W'(64'sd999999999999999999);
    localparam logic signed [POW_W-1:0] POW_MIN = -12'sd1254;
    localparam logic signed [POW_W-1:0] POW_MAX = 12'sd999;

    // Strings whose last character went in but whose result has not come out
    logic [2:0] r_pend;
    logic       last_in;
    logic       res_out;

    assign last_in = i_valid && o_ready && i_last_char;
    assign res_out = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + 3'(last_in) - 3'(res_out);
        end
    end

    // A result only for a string whose end mark was taken
    a_no_extra_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_out |-> (r_pend != 3'd0))
        else $error("result without a terminated string");

    // At most one string in each of the three stages
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 3'd3)
        else $error("too many strings in flight");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_significand)
            && $stable(o_power_of_ten) && $stable(o_digits_dropped)))
        else $error("stalled result changed");

    // Result fields stay within their ranges
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_significand <= SIG_MAX && o_significand >= -SIG_MAX
            && o_power_of_ten >= POW_MIN && o_power_of_ten <= POW_MAX))
        else $error("result field out of range");

endmodule

bind decimal_scientific_text_parser dstp_checker u_dstp_checker (.*);

`default_nettype wire
